>>> rtl/core/tdpt_pkg.sv
// Shared types and constants of the trial-division prime test core.
package tdpt_pkg;

	// Default width of the tested value
	localparam int VALUE_WIDTH_DEF = 32;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_TEST,
		ST_DONE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;        // capture candidate, divisor = 2, square = 4
		logic div_start;   // clear remainder, reload dividend shifter
		logic div_step;    // one restoring remainder step
		logic advance;     // next divisor, update running square
		logic verdict_we;  // latch verdict
		logic verdict_val; // verdict value: 1 = prime
		logic out_load;    // move verdict and value into the output register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic below_two;   // negative, zero or one
		logic sq_gt;       // divisor squared exceeds value
		logic div_done;    // remainder unit finished
		logic rem_zero;    // remainder is zero
	} status_t;

endpackage

>>> rtl/core/tdpt_in_if.sv
// Input channel: one candidate per beat.
interface tdpt_in_if #(
	parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] candidate;

	modport source (output valid, output candidate, input ready);
	modport sink (input valid, input candidate, output ready);
endinterface

>>> rtl/core/tdpt_out_if.sv
// Output channel: one verdict per beat.
interface tdpt_out_if #(
	parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	logic                   is_prime;
	logic [VALUE_WIDTH-1:0] marked_value;

	modport source (output valid, output is_prime, output marked_value, input ready);
	modport sink (input valid, input is_prime, input marked_value, output ready);
endinterface

>>> rtl/core/trial_division_prime_test_core.sv
// Trial-division prime test core: top level.
// Takes one signed candidate per input beat and returns one beat with is_prime and
// marked_value (the candidate when prime, all ones when not). Negative values, zero
// and one are not prime. Divisors 2, 3, ... are tried while divisor squared does not
// exceed the value; each try runs a bit-serial restoring remainder unit. A 32-bit
// prime near 2^31 tries about 46,340 divisors. One item is worked on at a time; the
// next candidate is taken as soon as the previous result sits in the output register,
// even if not yet taken.
module trial_division_prime_test_core #(
	parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tdpt_in_if.sink    in_ch,
	tdpt_out_if.source out_ch
);
	tdpt_pkg::cmd_t    cmd;
	tdpt_pkg::status_t st;

	tdpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.st        (st),
		.cmd       (cmd)
	);

	tdpt_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk          (clk),
		.cmd          (cmd),
		.candidate    (in_ch.candidate[VALUE_WIDTH-1:0]),
		.st           (st),
		.is_prime     (out_ch.is_prime),
		.marked_value (out_ch.marked_value[VALUE_WIDTH-1:0])
	);

endmodule

>>> rtl/core/tdpt_datapath.sv
// Datapath: value, divisor, running square, bit-serial remainder unit, output register.
module tdpt_datapath #(
	parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  tdpt_pkg::cmd_t         cmd,
	input  logic [VALUE_WIDTH-1:0] candidate,
	output tdpt_pkg::status_t      st,
	output logic                   is_prime,
	output logic [VALUE_WIDTH-1:0] marked_value
);
	localparam int W  = VALUE_WIDTH;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  value_q;
	logic [W-1:0]  div_q;
	logic [W-1:0]  sq_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dsh_q;
	logic [CW-1:0] cnt_q;
	logic          prime_q;
	logic          is_prime_q;
	logic [W-1:0]  marked_q;

	logic [W:0]    trial;
	logic [W:0]    diff;

	// Restoring remainder step: shift in next dividend bit, subtract if it fits
	assign trial = {rem_q, dsh_q[W-1]};
	assign diff  = trial - {1'b0, div_q};

	// Value and divisor bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= candidate;
			div_q   <= W'(2);
			sq_q    <= W'(4);
		end else if (cmd.advance) begin
			div_q <= div_q + W'(1);
			// (d+1)^2 = d^2 + 2d + 1
			sq_q  <= sq_q + {div_q[W-2:0], 1'b0} + W'(1);
		end
	end

	// Remainder unit, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			dsh_q <= value_q;
			cnt_q <= CW'(W);
		end else if (cmd.div_step) begin
			rem_q <= diff[W] ? trial[W-1:0] : diff[W-1:0];
			dsh_q <= {dsh_q[W-2:0], 1'b0};
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// Verdict and output register
	always_ff @(posedge clk) begin
		if (cmd.verdict_we) begin
			prime_q <= cmd.verdict_val;
		end
		if (cmd.out_load) begin
			is_prime_q <= prime_q;
			marked_q   <= prime_q ? value_q : '1;
		end
	end

	assign st.below_two = value_q[W-1] || (value_q < W'(2));
	assign st.sq_gt     = sq_q > value_q;
	assign st.div_done  = (cnt_q == '0);
	assign st.rem_zero  = (rem_q == '0);

	assign is_prime     = is_prime_q;
	assign marked_value = marked_q;

endmodule

>>> rtl/core/tdpt_ctrl.sv
// Controller: sequences the divisor loop and owns both handshakes.
module tdpt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  tdpt_pkg::status_t st,
	output tdpt_pkg::cmd_t    cmd
);
	tdpt_pkg::state_t state_q;
	tdpt_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || out_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdpt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output beat pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			tdpt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = tdpt_pkg::ST_CHECK;
				end
			end
			tdpt_pkg::ST_CHECK: begin
				priority if (st.below_two) begin
					cmd.verdict_we  = 1'b1;
					cmd.verdict_val = 1'b0;
					state_d         = tdpt_pkg::ST_DONE;
				end else if (st.sq_gt) begin
					// no divisor up to the square root divides: prime
					cmd.verdict_we  = 1'b1;
					cmd.verdict_val = 1'b1;
					state_d         = tdpt_pkg::ST_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = tdpt_pkg::ST_DIVIDE;
				end
			end
			tdpt_pkg::ST_DIVIDE: begin
				if (st.div_done) begin
					state_d = tdpt_pkg::ST_TEST;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			tdpt_pkg::ST_TEST: begin
				if (st.rem_zero) begin
					cmd.verdict_we  = 1'b1;
					cmd.verdict_val = 1'b0;
					state_d         = tdpt_pkg::ST_DONE;
				end else begin
					cmd.advance = 1'b1;
					state_d     = tdpt_pkg::ST_CHECK;
				end
			end
			tdpt_pkg::ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = tdpt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tdpt_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	// A pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while beat pending");

	// The next divisor is taken only after a full remainder pass
	a_advance_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> $past(state_q == tdpt_pkg::ST_DIVIDE) && $past(st.div_done))
		else $error("divisor advanced without finished remainder");

	// A new candidate is not taken while a test is in flight
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !in_ready)
		else $error("input accepted during a running test");
`endif

endmodule

>>> verif/trial_division_prime_test_core_tb.sv
// Testbench for the trial-division prime test core: directed and random candidates, scoreboard.
module trial_division_prime_test_core_tb;

	localparam int VW = tdpt_pkg::VALUE_WIDTH_DEF;
	// Worst item is the prime 2^31-1; the limit allows several times the whole run.
	localparam longint CYCLE_LIMIT = 10_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_ITEMS = 65;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic          is_prime;
		logic [VW-1:0] marked_value;
	} verdict_t;

	// Expected verdicts in arrival order, checked against output beats
	class verdict_board;
		verdict_t verdicts_due[$];
		int       faults;

		function new();
			faults = 0;
		endfunction

		// Trial division on the candidate taken as a signed value
		static function verdict_t primality_verdict(logic [VW-1:0] cand);
			verdict_t    v;
			logic [63:0] n;
			logic [63:0] d;
			bit          prime;
			n = 64'(cand);
			prime = !cand[VW-1] && (n >= 64'd2);
			for (d = 64'd2; prime && (d * d <= n); d++) begin
				if (n % d == 64'd0)
					prime = 1'b0;
			end
			v.is_prime = prime;
			v.marked_value = prime ? cand : '1;
			return v;
		endfunction

		function void note_candidate(logic [VW-1:0] cand);
			verdicts_due.push_back(primality_verdict(cand));
		endfunction

		function void check_verdict(logic is_prime, logic [VW-1:0] marked_value);
			verdict_t exp_v;
			if (verdicts_due.size() == 0) begin
				faults++;
				if (faults <= MAX_REPORTS)
					$display("unexpected verdict beat: is_prime=%0b marked_value=%0d",
						is_prime, $signed(marked_value));
				return;
			end
			exp_v = verdicts_due.pop_front();
			if (is_prime !== exp_v.is_prime || marked_value !== exp_v.marked_value) begin
				faults++;
				if (faults <= MAX_REPORTS)
					$display("verdict mismatch: exp %0b/%0d, got %0b/%0d",
						exp_v.is_prime, $signed(exp_v.marked_value), is_prime,
						$signed(marked_value));
			end
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	longint cycle_count;
	bit     hold_req;
	verdict_board sb;

	tdpt_in_if #(.VALUE_WIDTH(VW)) in_ch();
	tdpt_out_if #(.VALUE_WIDTH(VW)) out_ch();

	trial_division_prime_test_core #(.VALUE_WIDTH(VW)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Cycle limit
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("trial_division_prime_test_core_tb: FAIL");
				$finish;
			end
		end
	end

	// Result side: check beats, ready follows its own stall pattern plus one long hold-off
	initial begin : verdict_sink
		int hold_left;
		int mode;
		int mode_left;
		bit hold_taken;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		hold_taken = 1'b0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				sb.check_verdict(out_ch.is_prime, out_ch.marked_value);
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(5, 60);
				end
				mode_left--;
				unique case (mode)
					0: begin
						out_ch.ready <= 1'b1;
					end
					1: begin
						out_ch.ready <= ($urandom_range(0, 1) == 1);
					end
					default: begin
						out_ch.ready <= ($urandom_range(0, 3) == 0);
					end
				endcase
			end
		end
	end

	// Hold valid with this candidate until the block takes it
	task automatic offer_candidate(logic [VW-1:0] cand);
		in_ch.valid <= 1'b1;
		in_ch.candidate <= cand;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_candidate(cand);
	endtask

	task automatic idle_input(int cycles);
		if (cycles > 0) begin
			in_ch.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic wait_all_verdicts();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Random candidate; expensive primes are kept to modest sizes
	function automatic logic [VW-1:0] random_candidate();
		int          pick;
		logic [31:0] k;
		logic [31:0] p;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			return VW'($urandom_range(0, 200));
		else if (pick < 50)
			return VW'($urandom_range(2, 65535));
		else if (pick < 58)
			return VW'($urandom_range(65536, 262143) | 1);
		else if (pick < 68)
			return {1'b1, (VW-1)'($urandom)};
		else if (pick < 78) begin
			// large positive multiple of three
			k = $urandom_range(1, 715827882);
			return VW'(k * 32'd3);
		end else if (pick < 86)
			return {1'b0, (VW-2)'($urandom), 1'b0};
		else if (pick < 94) begin
			// composite with a small factor
			p = $urandom_range(2, 50);
			k = $urandom_range(2, 33554431);
			return VW'(p * k);
		end else begin
			// square k*k, so the square root is an exact divisor
			k = $urandom_range(2, 400);
			return VW'(k * k);
		end
	endfunction

	// Stimulus
	initial begin : candidate_source
		logic [VW-1:0] directed_set[$];
		int            sent;
		int            burst;
		sb = new();
		hold_req = 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.candidate <= '0;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: sign extremes, below two, two, squares, prime edges, largest prime
		directed_set = '{32'h8000_0000, 32'hFFFF_FFFF, -32'sd7, 32'd0, 32'd1, 32'd2,
			32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25, 32'd49, 32'd97, 32'd121,
			32'd561, 32'd7919, 32'd65521, 32'd65535, 32'd1000003, 32'h7FFF_FFFE,
			32'h7FFF_FFFD, 32'h5555_5555, 32'h2AAA_AAAA, 32'h7FFF_FFFF};
		foreach (directed_set[i]) begin
			offer_candidate(directed_set[i]);
			idle_input($urandom_range(0, 3));
		end
		idle_input(1);
		wait_all_verdicts();

		// Long receiver hold-off while cheap candidates keep coming
		hold_req = 1'b1;
		for (int i = 0; i < 10; i++)
			offer_candidate((i % 2 == 0) ? {1'b1, (VW-1)'($urandom)} :
				VW'($urandom_range(0, 40)));
		idle_input(1);
		wait_all_verdicts();

		// Random bursts with random gaps; some stretches run back to back
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
				offer_candidate(random_candidate());
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_input($urandom_range(1, 20));
		end
		idle_input(1);

		wait_all_verdicts();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.faults == 0 && sb.pending() == 0)
			$display("trial_division_prime_test_core_tb: PASS");
		else
			$display("trial_division_prime_test_core_tb: FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/tdpt_pkg.sv
rtl/core/tdpt_in_if.sv
rtl/core/tdpt_out_if.sv
rtl/core/tdpt_datapath.sv
rtl/core/tdpt_ctrl.sv
rtl/core/trial_division_prime_test_core.sv
verif/trial_division_prime_test_core_tb.sv
